FILE: rtl/sensor_beacon_decoder_table_unit_assert.svh
// Assertion macros for the beacon decoder table unit.
// Each macro expects signals named clock and reset in the including scope.
`ifndef SENSOR_BEACON_DECODER_TABLE_UNIT_ASSERT_SVH
`define SENSOR_BEACON_DECODER_TABLE_UNIT_ASSERT_SVH

// Condition holds on every clock edge out of reset.
`define SBDT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define SBDT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SBDT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sbdt_pkg.sv
// Shared constants, codes and controller/datapath types for the beacon decoder.
// No dependencies.
package sbdt_pkg;

   localparam int FRAME_LEN             = 26;
   localparam int COUNT_W               = 5;
   localparam int DATA_W                = 8;
   localparam int BOARD_W               = 24;
   localparam int WORD_W                = 16;
   localparam int STATUS_W              = 3;
   localparam int SLOT_W                = 3;
   localparam int CSR_INDEX_W           = 1;
   localparam int CSR_DATA_W            = 16;
   localparam int TABLE_ENTRIES_DEFAULT = 8;

   localparam logic [WORD_W-1:0] COMPANY_ID_RESET  = 16'h075B;
   localparam logic [DATA_W-1:0] BEACON_KIND_RESET = 8'h05;

   localparam logic [CSR_INDEX_W-1:0] CSR_COMPANY_ID  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEACON_KIND = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED    = 3'd0,
      ST_ADDED      = 3'd1,
      ST_TOO_SHORT  = 3'd2,
      ST_NOT_OURS   = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   typedef struct packed {
      logic take_byte;  // store one payload byte
      logic evaluate;   // check header, compare board against table
      logic commit;     // load result register, update table, restart frame
   } dp_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] byte_count;
      logic               table_full;
   } dp_status_type;

endpackage

FILE: rtl/sbdt_if.sv
// Valid/ready channels for payload bytes in and decoded results out.
// Depends on sbdt_pkg.
interface sbdt_req_if
   import sbdt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sbdt_rsp_if
   import sbdt_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [SLOT_W-1:0]        slot;
   logic [BOARD_W-1:0]       board_id;
   logic [DATA_W-1:0]        board_kind;
   logic [DATA_W-1:0]        voc_unit_kind;
   logic signed [WORD_W-1:0] temperature;
   logic [WORD_W-1:0]        pressure;
   logic [WORD_W-1:0]        humidity;
   logic [WORD_W-1:0]        voc_level;
   logic [WORD_W-1:0]        pm_one;
   logic [WORD_W-1:0]        pm_two_five;
   logic [WORD_W-1:0]        carbon_dioxide;

   modport source (output valid, output status, output slot, output board_id,
                   output board_kind, output voc_unit_kind, output temperature,
                   output pressure, output humidity, output voc_level, output pm_one,
                   output pm_two_five, output carbon_dioxide, input ready);
   modport sink   (input valid, input status, input slot, input board_id,
                   input board_kind, input voc_unit_kind, input temperature,
                   input pressure, input humidity, input voc_level, input pm_one,
                   input pm_two_five, input carbon_dioxide, output ready);
endinterface

FILE: rtl/sbdt_controller.sv
// Frame sequencer: collect bytes, evaluate, commit result into output register.
// Depends on sbdt_pkg.
module sbdt_controller
   import sbdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_COLLECT = 3'b001,
      S_MATCH   = 3'b010,
      S_RESOLVE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take, commit;

   assign req_ready = (state_ff == S_COLLECT);
   assign take      = req_valid && req_ready;
   // result register frees up in the same cycle it is drained
   assign commit    = (state_ff == S_RESOLVE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_COLLECT: begin
            if (take && req_last) state_in = S_MATCH;
         end
         S_MATCH: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            if (commit) state_in = S_COLLECT;
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign cmd.take_byte = take;
   assign cmd.evaluate  = (state_ff == S_MATCH);
   assign cmd.commit    = commit;

endmodule

FILE: rtl/sbdt_datapath.sv
// Frame buffer, board table with parallel match, config registers, result register.
// Depends on sbdt_pkg.
module sbdt_datapath
   import sbdt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic [DATA_W-1:0]        data_byte,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   output logic [STATUS_W-1:0]      out_status,
   output logic [SLOT_W-1:0]        out_slot,
   output logic [BOARD_W-1:0]       out_board_id,
   output logic [DATA_W-1:0]        out_board_kind,
   output logic [DATA_W-1:0]        out_voc_unit_kind,
   output logic signed [WORD_W-1:0] out_temperature,
   output logic [WORD_W-1:0]        out_pressure,
   output logic [WORD_W-1:0]        out_humidity,
   output logic [WORD_W-1:0]        out_voc_level,
   output logic [WORD_W-1:0]        out_pm_one,
   output logic [WORD_W-1:0]        out_pm_two_five,
   output logic [WORD_W-1:0]        out_carbon_dioxide
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [WORD_W-1:0]  company_id_ff;
   logic [DATA_W-1:0]  beacon_kind_ff;
   logic [DATA_W-1:0]  frame_ff [FRAME_LEN];
   logic [COUNT_W-1:0] byte_count_ff;
   logic [BOARD_W-1:0] board_ff [TABLE_ENTRIES];
   logic [CNT_W-1:0]   entry_count_ff;
   logic [TABLE_ENTRIES-1:0] match_ff;
   logic               short_ff, foreign_ff;

   logic [BOARD_W-1:0] board_now;
   logic [IDX_W-1:0]   hit_idx, slot_sel;
   logic               found, full, keep;
   status_type         verdict;

   assign board_now = {frame_ff[4], frame_ff[5], frame_ff[6]};
   assign full      = (entry_count_ff >= CNT_W'(TABLE_ENTRIES));
   assign found     = |match_ff;

   // lowest matching entry wins
   always_comb begin
      hit_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = IDX_W'(i);
      end
   end

   always_comb begin
      if (short_ff) begin
         verdict = ST_TOO_SHORT;
      end else if (foreign_ff) begin
         verdict = ST_NOT_OURS;
      end else if (found) begin
         verdict = ST_UPDATED;
      end else if (full) begin
         verdict = ST_TABLE_FULL;
      end else begin
         verdict = ST_ADDED;
      end
   end

   assign keep     = (verdict == ST_UPDATED) || (verdict == ST_ADDED);
   assign slot_sel = found ? hit_idx : entry_count_ff[IDX_W-1:0];

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         company_id_ff  <= COMPANY_ID_RESET;
         beacon_kind_ff <= BEACON_KIND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COMPANY_ID:  company_id_ff  <= csr_write_data[WORD_W-1:0];
            CSR_BEACON_KIND: beacon_kind_ff <= csr_write_data[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // frame byte capture, saturating count
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else if (cmd.commit) begin
         byte_count_ff <= '0;
      end else if (cmd.take_byte && (byte_count_ff < COUNT_W'(FRAME_LEN))) begin
         byte_count_ff <= byte_count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < FRAME_LEN; k++) begin
         if (cmd.take_byte && (byte_count_ff == COUNT_W'(k))) frame_ff[k] <= data_byte;
      end
   end

   // evaluate stage: header check and parallel compare against live entries
   always_ff @(posedge clock) begin
      if (cmd.evaluate) begin
         short_ff   <= (byte_count_ff < COUNT_W'(FRAME_LEN));
         foreign_ff <= ({frame_ff[1], frame_ff[0]} != company_id_ff) ||
                       (frame_ff[2] != beacon_kind_ff);
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_ff[i] <= (board_ff[i] == board_now) && (CNT_W'(i) < entry_count_ff);
         end
      end
   end

   // table append
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (cmd.commit && (verdict == ST_ADDED)) begin
         entry_count_ff <= entry_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (cmd.commit && (verdict == ST_ADDED) && (slot_sel == IDX_W'(i))) begin
            board_ff[i] <= board_now;
         end
      end
   end

   // result register; ignored frames carry only the status
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status <= verdict;
         if (keep) begin
            out_slot           <= SLOT_W'(slot_sel);
            out_board_id       <= board_now;
            out_board_kind     <= frame_ff[3];
            out_voc_unit_kind  <= frame_ff[25];
            out_temperature    <= {frame_ff[12], frame_ff[11]};
            out_pressure       <= {frame_ff[10], frame_ff[9]};
            out_humidity       <= {frame_ff[14], frame_ff[13]};
            out_voc_level      <= {frame_ff[16], frame_ff[15]};
            out_pm_one         <= {frame_ff[18], frame_ff[17]};
            out_pm_two_five    <= {frame_ff[20], frame_ff[19]};
            out_carbon_dioxide <= {frame_ff[23], frame_ff[24]};
         end else begin
            out_slot           <= '0;
            out_board_id       <= '0;
            out_board_kind     <= '0;
            out_voc_unit_kind  <= '0;
            out_temperature    <= '0;
            out_pressure       <= '0;
            out_humidity       <= '0;
            out_voc_level      <= '0;
            out_pm_one         <= '0;
            out_pm_two_five    <= '0;
            out_carbon_dioxide <= '0;
         end
      end
   end

   assign status.byte_count = byte_count_ff;
   assign status.table_full = full;

endmodule

FILE: rtl/sensor_beacon_decoder_table_unit.sv
// Top level of the beacon decoder with its table of known boards.
// Depends on sbdt_pkg, sbdt_if, sbdt_controller, sbdt_datapath and the assert header.
//
// Usage:
//   req_chan carries one advertisement payload byte per beat, starting at the
//   little-endian company id; last_byte marks the final beat of the payload.
//   Bytes beyond the 26th are dropped. Only the final beat yields a beat on
//   rsp_chan: status, slot of the matched or added board, and decoded readings.
//   csr_* writes company_id (index 0) and beacon_kind (index 1); write only idle.
// Timing:
//   Non-final bytes are taken at one per cycle. After the final byte the block
//   moves to the match state for the header check and parallel board compare,
//   then to the resolve state, which picks the slot and loads the result
//   register once that register is free; rsp valid rises with the load.
// Stall:
//   The result register holds a finished result while the next frame streams
//   in; only the next frame's resolve step waits for it to be taken, and
//   req ready stays low until then.
// Reset:
//   Clears the byte count, the table fill count and the result valid, and
//   restores both config registers; table and frame contents stay undefined.
`include "sensor_beacon_decoder_table_unit_assert.svh"

module sensor_beacon_decoder_table_unit
   import sbdt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)(
   input  logic                   clock,
   input  logic                   reset,
   sbdt_req_if.sink               req_chan,
   sbdt_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;
   logic          req_ready;
   logic          rsp_valid;

   // sequencer: owns handshake and result-valid state
   sbdt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_byte),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // storage, compare and result payload
   sbdt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (dp_status),
      .data_byte          (req_chan.data_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .out_status         (rsp_chan.status),
      .out_slot           (rsp_chan.slot),
      .out_board_id       (rsp_chan.board_id),
      .out_board_kind     (rsp_chan.board_kind),
      .out_voc_unit_kind  (rsp_chan.voc_unit_kind),
      .out_temperature    (rsp_chan.temperature),
      .out_pressure       (rsp_chan.pressure),
      .out_humidity       (rsp_chan.humidity),
      .out_voc_level      (rsp_chan.voc_level),
      .out_pm_one         (rsp_chan.pm_one),
      .out_pm_two_five    (rsp_chan.pm_two_five),
      .out_carbon_dioxide (rsp_chan.carbon_dioxide)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // byte count saturates at the frame length
   `SBDT_ASSERT_ALWAYS(a_count_sat, dp_status.byte_count <= COUNT_W'(FRAME_LEN), "byte count overran")

   // final beat closes the input until the result is committed
   `SBDT_ASSERT_NEXT(a_last_blocks, req_chan.valid && req_ready && req_chan.last_byte, !req_ready, "input open after final beat")

   // ignored frames carry zero slot and board
   `SBDT_ASSERT_IMPLIES(a_ignored_zero, rsp_valid && (rsp_chan.status == ST_TOO_SHORT || rsp_chan.status == ST_NOT_OURS || rsp_chan.status == ST_TABLE_FULL), rsp_chan.slot == '0 && rsp_chan.board_id == '0, "ignored frame leaked payload")

   // a table-full verdict needs a full table
   `SBDT_ASSERT_IMPLIES(a_full_consistent, rsp_valid && rsp_chan.status == ST_TABLE_FULL, dp_status.table_full, "table full reported with room left")

endmodule

FILE: tb/sensor_beacon_decoder_table_unit_tb.sv
// Self-checking bench for the beacon decoder with its table of known boards.
// Streams advertisement payloads over the request channel and checks every result beat.
// Depends on sbdt_pkg, sbdt_if and sensor_beacon_decoder_table_unit.
module sensor_beacon_decoder_table_unit_tb
   import sbdt_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int BOARD_SLOTS = TABLE_ENTRIES_DEFAULT;

   // One decoded beacon report, as the result channel should carry it.
   typedef struct packed {
      status_type               status;
      logic [SLOT_W-1:0]        slot;
      logic [BOARD_W-1:0]       board_id;
      logic [DATA_W-1:0]        board_kind;
      logic [DATA_W-1:0]        voc_unit_kind;
      logic signed [WORD_W-1:0] temperature;
      logic [WORD_W-1:0]        pressure;
      logic [WORD_W-1:0]        humidity;
      logic [WORD_W-1:0]        voc_level;
      logic [WORD_W-1:0]        pm_one;
      logic [WORD_W-1:0]        pm_two_five;
      logic [WORD_W-1:0]        carbon_dioxide;
   } beacon_report_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   sbdt_req_if req_chan ();
   sbdt_rsp_if rsp_chan ();

   sensor_beacon_decoder_table_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the block: frame buffer, byte count, board table and registers.
   logic [DATA_W-1:0]  frame_mem [FRAME_LEN];
   int                 frame_fill;
   logic [BOARD_W-1:0] known_table [BOARD_SLOTS];
   int                 table_fill;
   logic [WORD_W-1:0]  company_reg;
   logic [DATA_W-1:0]  beacon_kind_reg;

   beacon_report_type  pending_reports[$];   // reports owed by the block, oldest first
   logic [DATA_W-1:0]  payload[$];           // payload being built by a test
   logic [BOARD_W-1:0] seen_boards[$];       // board ids handed out by the random traffic

   int  mismatches = 0;
   int  bytes_sent = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  sender_idle = 1'b0;
   bit  receiver_stall = 1'b0;

   // ------------------------------------------------------------------
   // Predictor: absorbs one accepted payload byte; a final byte owes one report.
   // ------------------------------------------------------------------
   function automatic void decode_byte(input logic [DATA_W-1:0] b, input logic last);
      beacon_report_type  r;
      int                 count;
      int                 hit;
      logic [BOARD_W-1:0] board;
      // bytes beyond the frame are dropped, the count saturates
      if (frame_fill < FRAME_LEN) begin
         frame_mem[frame_fill] = b;
         frame_fill++;
      end
      if (!last) return;
      count      = frame_fill;
      frame_fill = 0;
      r          = '0;
      if (count < FRAME_LEN) begin
         r.status = ST_TOO_SHORT;
      end else if ({frame_mem[1], frame_mem[0]} != company_reg ||
                   frame_mem[2] != beacon_kind_reg) begin
         r.status = ST_NOT_OURS;
      end else begin
         board = {frame_mem[4], frame_mem[5], frame_mem[6]};
         hit   = -1;
         for (int i = 0; i < table_fill; i++) begin
            if (hit < 0 && known_table[i] == board) hit = i;
         end
         if (hit < 0 && table_fill >= BOARD_SLOTS) begin
            r.status = ST_TABLE_FULL;
         end else begin
            if (hit >= 0) begin
               r.status = ST_UPDATED;
            end else begin
               hit              = table_fill;
               known_table[hit] = board;
               table_fill++;
               r.status = ST_ADDED;
            end
            r.slot           = hit[SLOT_W-1:0];
            r.board_id       = board;
            r.board_kind     = frame_mem[3];
            r.voc_unit_kind  = frame_mem[25];
            r.temperature    = {frame_mem[12], frame_mem[11]};
            r.pressure       = {frame_mem[10], frame_mem[9]};
            r.humidity       = {frame_mem[14], frame_mem[13]};
            r.voc_level      = {frame_mem[16], frame_mem[15]};
            r.pm_one         = {frame_mem[18], frame_mem[17]};
            r.pm_two_five    = {frame_mem[20], frame_mem[19]};
            r.carbon_dioxide = {frame_mem[23], frame_mem[24]};   // big endian
         end
      end
      pending_reports.push_back(r);
   endfunction

   // Gap before a request beat: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (!sender_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic bit is_listed(input logic [BOARD_W-1:0] board);
      for (int i = 0; i < table_fill; i++) begin
         if (known_table[i] == board) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Fills payload with random bytes and a well-formed header for the current
   // registers; header bytes past the length are simply not there.
   function automatic void form_frame(input logic [BOARD_W-1:0] board, input int length);
      logic [DATA_W-1:0] head [7];
      head[0] = company_reg[7:0];
      head[1] = company_reg[15:8];
      head[2] = beacon_kind_reg;
      head[3] = 8'h00;
      head[4] = board[23:16];
      head[5] = board[15:8];
      head[6] = board[7:0];
      payload.delete();
      for (int i = 0; i < length; i++) payload.push_back(DATA_W'($urandom_range(0, 255)));
      for (int i = 0; i < 7 && i < length; i++) begin
         if (i != 3) payload[i] = head[i];
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // One beat on the request channel. Valid stays high into the next beat
   // when no gap is drawn, so it is never dropped and raised in one step.
   task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      decode_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_payload();
      foreach (payload[i]) send_byte(payload[i], i == payload.size() - 1);
   endtask

   // Drop valid and let every owed report drain, plus the resolve latency.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Both registers are written back to back, only with the block idle.
   task automatic configure(input logic [CSR_DATA_W-1:0] company,
                            input logic [CSR_DATA_W-1:0] kind);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_COMPANY_ID;
      csr_write_data   <= company;
      @(posedge clock);
      company_reg      = company;
      csr_index        <= CSR_BEACON_KIND;
      csr_write_data   <= kind;
      @(posedge clock);
      beacon_kind_reg  = kind[DATA_W-1:0];   // upper data bits are dropped
      csr_write_enable <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result side: compare each beat against the oldest owed report, then
   // pick ready for the next cycle.
   // ------------------------------------------------------------------
   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      beacon_report_type want;
      int                r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_reports.size() == 0) begin
            $error("result beat with no report pending");
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("status", int'(want.status), int'(rsp_chan.status));
            compare_field("slot", int'(want.slot), int'(rsp_chan.slot));
            compare_field("board_id", int'(want.board_id), int'(rsp_chan.board_id));
            compare_field("board_kind", int'(want.board_kind), int'(rsp_chan.board_kind));
            compare_field("voc_unit_kind", int'(want.voc_unit_kind),
                          int'(rsp_chan.voc_unit_kind));
            compare_field("temperature", int'($signed(want.temperature)),
                          int'($signed(rsp_chan.temperature)));
            compare_field("pressure", int'(want.pressure), int'(rsp_chan.pressure));
            compare_field("humidity", int'(want.humidity), int'(rsp_chan.humidity));
            compare_field("voc_level", int'(want.voc_level), int'(rsp_chan.voc_level));
            compare_field("pm_one", int'(want.pm_one), int'(rsp_chan.pm_one));
            compare_field("pm_two_five", int'(want.pm_two_five), int'(rsp_chan.pm_two_five));
            compare_field("carbon_dioxide", int'(want.carbon_dioxide),
                          int'(rsp_chan.carbon_dioxide));
         end
      end
      // back-pressure: runs of ready broken by short and occasional long stalls
      if (!receiver_stall) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            stall_left = (r < 92) ? $urandom_range(0, 3) : $urandom_range(8, 40);
            rsp_chan.ready <= 1'b0;
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Final byte before 26 bytes: too short, whatever the header holds.
   task automatic test_short_payloads();
      sender_idle    = 1'b1;
      receiver_stall = 1'b1;
      form_frame(24'h123456, 1);     // lone final byte
      send_payload();
      form_frame(24'h123456, 2);
      send_payload();
      form_frame(24'h123456, 25);    // one byte short, header fine
      send_payload();
   endtask

   // Full-length frames with a header that does not match the registers.
   task automatic test_foreign_frames();
      form_frame(24'h00A0B0, FRAME_LEN);
      payload[0] ^= 8'h01;           // company id, low byte
      send_payload();
      form_frame(24'h00A0B0, FRAME_LEN);
      payload[1] ^= 8'h80;           // company id, high byte
      send_payload();
      form_frame(24'h00A0B0, FRAME_LEN);
      payload[2] ^= 8'h80;           // beacon kind
      send_payload();
   endtask

   // New boards are added, repeats update their slot; reading extremes.
   task automatic test_board_table();
      form_frame(24'h000000, FRAME_LEN);
      payload[3] = 8'h00;
      for (int i = 7; i < FRAME_LEN; i++) payload[i] = 8'h00;
      send_payload();
      form_frame(24'hFFFFFF, FRAME_LEN);
      payload[3] = 8'hFF;
      for (int i = 7; i < FRAME_LEN; i++) payload[i] = 8'hFF;
      send_payload();
      form_frame(24'h000000, FRAME_LEN);
      payload[11] = 8'h00;           // most negative temperature
      payload[12] = 8'h80;
      send_payload();
      form_frame(24'hFFFFFF, 34);    // long payload: the tail is dropped
      payload[11] = 8'hFF;           // most positive temperature
      payload[12] = 8'h7F;
      send_payload();
   endtask

   // Register extremes; the beacon kind keeps only its low byte.
   task automatic test_registers();
      configure(16'h0000, 16'h0000);
      form_frame(24'h5A5A5A, FRAME_LEN);
      send_payload();
      configure(16'hFFFF, 16'hA5FF);
      form_frame(24'hA5A5A5, FRAME_LEN);
      send_payload();
      form_frame(24'hA5A5A5, FRAME_LEN);
      payload[0] = COMPANY_ID_RESET[7:0];
      payload[1] = COMPANY_ID_RESET[15:8];
      payload[2] = BEACON_KIND_RESET;
      send_payload();
      form_frame(24'hA5A5A5, FRAME_LEN);
      payload[2] = 8'hA5;            // upper data byte written must not count
      send_payload();
      configure(COMPANY_ID_RESET, {8'h00, BEACON_KIND_RESET});
      form_frame(24'h5A5A5A, FRAME_LEN);
      send_payload();
   endtask

   // Mostly well-formed frames with random content and boards drawn from a
   // small pool, plus broken headers, short payloads and plain noise.
   task automatic test_random_traffic();
      int                 goal;
      int                 r;
      int                 length;
      logic [BOARD_W-1:0] board;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: configure(COMPANY_ID_RESET, {8'h00, BEACON_KIND_RESET});
            1: configure(16'h0000, 16'h0000);
            2: configure(16'hFFFF, 16'hFFFF);
            default: configure(CSR_DATA_W'($urandom_range(0, 65535)),
                               CSR_DATA_W'($urandom_range(0, 65535)));
         endcase
         // first phase runs with no idling on either side
         sender_idle    = (phase != 0);
         receiver_stall = (phase != 0);
         goal = bytes_sent + 290;
         while (bytes_sent < goal) begin
            if (seen_boards.size() != 0 && $urandom_range(0, 99) < 60) begin
               board = seen_boards[$urandom_range(0, seen_boards.size() - 1)];
            end else begin
               board = BOARD_W'($urandom());
               seen_boards.push_back(board);
            end
            r      = $urandom_range(0, 99);
            length = ($urandom_range(0, 99) < 15) ? $urandom_range(27, 40) : FRAME_LEN;
            if (r < 70) begin
               form_frame(board, length);
            end else if (r < 80) begin
               form_frame(board, length);
               payload[$urandom_range(0, 2)] ^= DATA_W'(1 << $urandom_range(0, 7));
            end else if (r < 90) begin
               form_frame(board, $urandom_range(1, FRAME_LEN - 1));
            end else begin
               payload.delete();
               repeat ($urandom_range(1, 40)) payload.push_back(DATA_W'($urandom()));
            end
            send_payload();
         end
      end
   endtask

   // Fill whatever room is left, then a stranger is refused while known
   // boards still update.
   task automatic test_table_full();
      logic [BOARD_W-1:0] board;
      sender_idle    = 1'b1;
      receiver_stall = 1'b1;
      while (table_fill < BOARD_SLOTS) begin
         do board = BOARD_W'($urandom()); while (is_listed(board));
         form_frame(board, FRAME_LEN);
         send_payload();
      end
      do board = BOARD_W'($urandom()); while (is_listed(board));
      form_frame(board, FRAME_LEN);
      send_payload();
      form_frame(known_table[BOARD_SLOTS - 1], FRAME_LEN);
      send_payload();
      form_frame(known_table[0], 30);
      send_payload();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.last_byte <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_index          <= CSR_COMPANY_ID;
      csr_write_data     <= '0;
      frame_fill         = 0;
      table_fill         = 0;
      company_reg        = COMPANY_ID_RESET;
      beacon_kind_reg    = BEACON_KIND_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_payloads();
      test_foreign_frames();
      test_board_table();
      test_registers();
      test_random_traffic();
      test_table_full();

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
